// ----- design/rasst_pkg.sv -----
// Shared widths, frame phase codes and controller/datapath handshake structs.
package rasst_pkg;

    localparam int POS_W    = 11;
    localparam int VAL_IN_W = 16;
    localparam int SUM_W    = 26;

    // Progress of one stack frame
    localparam logic [1:0] PH_ENTER = 2'd0;
    localparam logic [1:0] PH_LEFT  = 2'd1;
    localparam logic [1:0] PH_RIGHT = 2'd2;
    localparam logic [1:0] PH_JOIN  = 2'd3;

    typedef struct packed {
        logic clr_start;
        logic clr_step;
        logic load;
        logic push_root;
        logic pop;
        logic adv_phase;
        logic push_left;
        logic push_right;
        logic rd_top;
        logic rd_l;
        logic rd_r;
        logic wr_set;
        logic wr_pd_l;
        logic wr_pd_r;
        logic wr_pd_n;
        logic latch_tmp;
        logic wr_sum;
        logic acc_add;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic       clr_done;
        logic       trivial;
        logic       stk_empty;
        logic [1:0] phase;
        logic       skip;
        logic       full;
        logic       is_query;
        logic       pend;
        logic       go_left;
        logic       go_right;
        logic       has_right;
        logic       out_free;
    } t_sts;

endpackage

// ----- design/rasst_ctrl.sv -----
// Sequencer for clearing, tree walk and result hand-off.
module rasst_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_cfg_valid,
    input  rasst_pkg::t_sts    i_sts,
    output logic               o_in_ready,
    output rasst_pkg::t_cmd    o_cmd
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_START = 4'd2;
    localparam logic [3:0] S_VISIT = 4'd3;
    localparam logic [3:0] S_PD    = 4'd4;
    localparam logic [3:0] S_PD2   = 4'd5;
    localparam logic [3:0] S_PD3   = 4'd6;
    localparam logic [3:0] S_QADD  = 4'd7;
    localparam logic [3:0] S_SUM1  = 4'd8;
    localparam logic [3:0] S_SUM2  = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_in_ready = (r_state == S_IDLE) && !i_cfg_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        if (i_cfg_valid) begin
            o_cmd.clr_start = 1'b1;
            n_state         = S_CLEAR;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    o_cmd.clr_step = 1'b1;
                    if (i_sts.clr_done) n_state = S_IDLE;
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_START;
                    end
                end
                S_START: begin
                    if (i_sts.trivial) begin
                        n_state = S_FIN;
                    end else begin
                        o_cmd.push_root = 1'b1;
                        n_state         = S_VISIT;
                    end
                end
                S_VISIT: begin
                    if (i_sts.stk_empty) begin
                        n_state = S_FIN;
                    end else begin
                        unique case (i_sts.phase)
                            rasst_pkg::PH_ENTER: begin
                                if (i_sts.skip) begin
                                    o_cmd.pop = 1'b1;
                                end else if (i_sts.full && !i_sts.is_query) begin
                                    o_cmd.wr_set = 1'b1;
                                    o_cmd.pop    = 1'b1;
                                end else if (i_sts.full) begin
                                    o_cmd.rd_top = 1'b1;
                                    n_state      = S_QADD;
                                end else begin
                                    o_cmd.rd_top = 1'b1;
                                    n_state      = S_PD;
                                end
                            end
                            rasst_pkg::PH_LEFT: begin
                                o_cmd.adv_phase = 1'b1;
                                o_cmd.push_left = i_sts.go_left;
                            end
                            rasst_pkg::PH_RIGHT: begin
                                o_cmd.adv_phase  = 1'b1;
                                o_cmd.push_right = i_sts.go_right;
                            end
                            rasst_pkg::PH_JOIN: begin
                                if (!i_sts.is_query && i_sts.has_right) begin
                                    o_cmd.rd_l = 1'b1;
                                    n_state    = S_SUM1;
                                end else begin
                                    o_cmd.pop = 1'b1;
                                end
                            end
                            default: o_cmd.pop = 1'b1;
                        endcase
                    end
                end
                S_PD: begin
                    if (i_sts.pend) begin
                        o_cmd.wr_pd_l = 1'b1;
                        n_state       = S_PD2;
                    end else begin
                        o_cmd.adv_phase = 1'b1;
                        n_state         = S_VISIT;
                    end
                end
                S_PD2: begin
                    o_cmd.wr_pd_r = 1'b1;
                    n_state       = S_PD3;
                end
                S_PD3: begin
                    o_cmd.wr_pd_n   = 1'b1;
                    o_cmd.adv_phase = 1'b1;
                    n_state         = S_VISIT;
                end
                S_QADD: begin
                    o_cmd.acc_add = 1'b1;
                    o_cmd.pop     = 1'b1;
                    n_state       = S_VISIT;
                end
                S_SUM1: begin
                    o_cmd.latch_tmp = 1'b1;
                    o_cmd.rd_r      = 1'b1;
                    n_state         = S_SUM2;
                end
                S_SUM2: begin
                    o_cmd.wr_sum = 1'b1;
                    o_cmd.pop    = 1'b1;
                    n_state      = S_VISIT;
                end
                S_FIN: begin
                    if (i_sts.out_free) begin
                        o_cmd.fin = 1'b1;
                        n_state   = S_IDLE;
                    end
                end
                default: n_state = S_CLEAR;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- design/rasst_dp.sv -----
// Node memory, frame stack, shared multiplier and result register.
module rasst_dp #(
    parameter int LEAVES     = 1024,
    parameter int VALUE_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rasst_pkg::t_cmd                i_cmd,
    output rasst_pkg::t_sts                o_sts,
    input  logic                           i_cfg_valid,
    input  logic [rasst_pkg::POS_W-1:0]    i_cfg_used_length,
    input  logic                           i_operation,
    input  logic [rasst_pkg::POS_W-1:0]    i_left,
    input  logic [rasst_pkg::POS_W-1:0]    i_right,
    input  logic [rasst_pkg::VAL_IN_W-1:0] i_value,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [rasst_pkg::SUM_W-1:0]    o_range_sum,
    output logic                           o_status
);

    localparam int NODES = 2 * LEAVES;
    localparam int AW    = $clog2(NODES);
    localparam int NIW   = AW + 1;
    localparam int PW    = ($clog2(LEAVES + 1) > rasst_pkg::POS_W) ?
                           $clog2(LEAVES + 1) : rasst_pkg::POS_W;
    localparam int SD    = $clog2(LEAVES) + 2;
    localparam int SIW   = $clog2(SD);
    localparam int SPW   = $clog2(SD + 1);
    localparam int SW    = rasst_pkg::SUM_W;

    typedef struct packed {
        logic [NIW-1:0] n;
        logic [PW-1:0]  lo;
        logic [PW-1:0]  hi;
        logic [PW-1:0]  a;
        logic [PW-1:0]  b;
        logic [1:0]     ph;
    } t_frame;

    typedef struct packed {
        logic                  flag;
        logic [VALUE_BITS-1:0] pv;
        logic [SW-1:0]         sum;
    } t_word;

    t_word  r_mem [NODES];
    t_word  r_rd;
    t_frame r_stk [SD];
    logic [SPW-1:0]        r_sp;
    logic [AW-1:0]         r_cnt;
    logic [PW-1:0]         r_len;
    logic                  r_op;
    logic [PW-1:0]         r_a;
    logic [PW-1:0]         r_b;
    logic [VALUE_BITS-1:0] r_val;
    logic [SW-1:0]         r_tmp;
    logic [SW-1:0]         r_acc;
    logic                  r_ov;
    logic [SW-1:0]         r_osum;
    logic                  r_ostat;

    logic [31:0]   cfg_w;
    logic [PW-1:0] n_len;
    logic [SIW-1:0] top_idx;
    t_frame top, root, child_l, child_r;
    logic [PW-1:0] mid;
    logic [NIW-1:0] cl, cr;
    logic cl_ok, cr_ok;
    logic empty, oob;
    logic [PW-1:0] m_len;
    logic [VALUE_BITS-1:0] m_val;
    logic [PW+VALUE_BITS-1:0] prod_full;
    logic [SW-1:0] prod;
    logic rd_en, we;
    logic [AW-1:0] raddr, waddr;
    t_word wdata;

    // saturate the register write into 1..LEAVES
    always_comb begin
        cfg_w = 32'(i_cfg_used_length);
        if (cfg_w == 32'd0) begin
            n_len = PW'(1);
        end else if (cfg_w > 32'(LEAVES)) begin
            n_len = PW'(LEAVES);
        end else begin
            n_len = PW'(cfg_w);
        end
    end

    assign empty = r_a > r_b;
    assign oob   = (r_a == '0) || (r_b > r_len);

    assign top_idx = SIW'(r_sp - 1'b1);
    assign top     = r_stk[top_idx];
    assign mid     = PW'(({1'b0, top.lo} + {1'b0, top.hi}) >> 1);
    assign cl      = {top.n[NIW-2:0], 1'b0};
    assign cr      = {top.n[NIW-2:0], 1'b1};
    assign cl_ok   = cl < NIW'(NODES);
    assign cr_ok   = cr < NIW'(NODES);

    always_comb begin
        root    = '{n: NIW'(1), lo: PW'(1), hi: r_len, a: r_a, b: r_b,
                    ph: rasst_pkg::PH_ENTER};
        child_l = '{n: cl, lo: top.lo, hi: mid, a: top.a,
                    b: (top.b < mid) ? top.b : mid, ph: rasst_pkg::PH_ENTER};
        child_r = '{n: cr, lo: mid + 1'b1, hi: top.hi,
                    a: (top.a > mid + 1'b1) ? top.a : mid + 1'b1, b: top.b,
                    ph: rasst_pkg::PH_ENTER};
    end

    always_comb begin
        o_sts.clr_done  = r_cnt == AW'(NODES - 1);
        o_sts.trivial   = empty || oob;
        o_sts.stk_empty = r_sp == '0;
        o_sts.phase     = top.ph;
        o_sts.skip      = (top.n >= NIW'(NODES)) || (top.a > top.b);
        o_sts.full      = (top.a == top.lo) && (top.b == top.hi);
        o_sts.is_query  = r_op;
        o_sts.pend      = r_rd.flag;
        o_sts.go_left   = top.a <= mid;
        o_sts.go_right  = top.b > mid;
        o_sts.has_right = cr_ok;
        o_sts.out_free  = !r_ov || i_out_ready;
    end

    // one multiplier: span length times assigned value
    always_comb begin
        if (i_cmd.wr_pd_l) begin
            m_len = mid - top.lo + 1'b1;
            m_val = r_rd.pv;
        end else if (i_cmd.wr_pd_r) begin
            m_len = top.hi - mid;
            m_val = r_rd.pv;
        end else begin
            m_len = top.hi - top.lo + 1'b1;
            m_val = r_val;
        end
        prod_full = m_len * m_val;
        prod      = SW'(prod_full);
    end

    always_comb begin
        rd_en = 1'b0;
        raddr = top.n[AW-1:0];
        if (i_cmd.rd_top) begin
            rd_en = !o_sts.skip;
        end else if (i_cmd.rd_l) begin
            rd_en = cl_ok;
            raddr = cl[AW-1:0];
        end else if (i_cmd.rd_r) begin
            rd_en = cr_ok;
            raddr = cr[AW-1:0];
        end
    end

    always_comb begin
        we    = 1'b0;
        waddr = top.n[AW-1:0];
        wdata = '{flag: 1'b0, pv: r_rd.pv, sum: r_rd.sum};
        if (i_cmd.clr_step) begin
            we    = 1'b1;
            waddr = r_cnt;
            wdata = '0;
        end else if (i_cmd.wr_set) begin
            we    = !o_sts.skip;
            wdata = '{flag: 1'b1, pv: r_val, sum: prod};
        end else if (i_cmd.wr_pd_l) begin
            we    = cl_ok;
            waddr = cl[AW-1:0];
            wdata = '{flag: 1'b1, pv: r_rd.pv, sum: prod};
        end else if (i_cmd.wr_pd_r) begin
            we    = cr_ok;
            waddr = cr[AW-1:0];
            wdata = '{flag: 1'b1, pv: r_rd.pv, sum: prod};
        end else if (i_cmd.wr_pd_n) begin
            we = 1'b1;
        end else if (i_cmd.wr_sum) begin
            we    = 1'b1;
            wdata = '{flag: 1'b0, pv: r_rd.pv, sum: r_tmp + r_rd.sum};
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) r_rd <= r_mem[raddr];
    end

    // frame stack payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.push_root) begin
            r_stk[0] <= root;
        end else begin
            if (i_cmd.adv_phase) r_stk[top_idx].ph <= top.ph + 2'd1;
            if (i_cmd.push_left) r_stk[r_sp[SIW-1:0]] <= child_l;
            else if (i_cmd.push_right) r_stk[r_sp[SIW-1:0]] <= child_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp  <= '0;
            r_cnt <= '0;
            r_len <= PW'(LEAVES);
            r_ov  <= 1'b0;
        end else begin
            if (i_cfg_valid) r_len <= n_len;
            if (i_cmd.clr_start || i_cmd.load) begin
                r_sp <= '0;
            end else if (i_cmd.push_root) begin
                r_sp <= SPW'(1);
            end else if (i_cmd.push_left || i_cmd.push_right) begin
                r_sp <= r_sp + 1'b1;
            end else if (i_cmd.pop) begin
                r_sp <= r_sp - 1'b1;
            end
            if (i_cmd.clr_start) begin
                r_cnt <= '0;
            end else if (i_cmd.clr_step) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.fin) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_operation;
            r_a   <= PW'(i_left);
            r_b   <= PW'(i_right);
            r_val <= VALUE_BITS'(32'(i_value));
            r_acc <= '0;
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + r_rd.sum;
        end
        if (i_cmd.latch_tmp) r_tmp <= r_rd.sum;
        if (i_cmd.fin) begin
            r_osum  <= r_acc;
            r_ostat <= !empty && oob;
        end
    end

    assign o_out_valid = r_ov;
    assign o_range_sum = r_osum;
    assign o_status    = r_ostat;

endmodule

// ----- design/range_assign_range_sum_tree.sv -----
// Top level: lazy range-assign / range-sum tree with request and config channels.
// Empty or out-of-bounds requests skip the tree walk and go straight to the result; others
//   walk the tree node by node (single-port node memory, one read or write per cycle).
// Throughput: one request in flight; the next is taken while the result waits.
// Reset and every used_length write run a clearing pass over all 2*LEAVES node memory words
//   (2048 at default); no request is taken until it ends.
module range_assign_range_sum_tree #(
    parameter int LEAVES     = 1024,
    parameter int VALUE_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rasst_pkg::POS_W-1:0]    i_cfg_used_length,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_operation,
    input  logic [rasst_pkg::POS_W-1:0]    i_left,
    input  logic [rasst_pkg::POS_W-1:0]    i_right,
    input  logic [rasst_pkg::VAL_IN_W-1:0] i_value,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [rasst_pkg::SUM_W-1:0]    o_range_sum,
    output logic                           o_status
);

    rasst_pkg::t_cmd cmd;
    rasst_pkg::t_sts sts;

    // config writes are always taken; they abort to a clearing pass
    assign o_cfg_ready = 1'b1;

    // controller: walks the recursion one frame step at a time
    rasst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cfg_valid(i_cfg_valid),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // datapath: node memory, frame stack, span multiplier, result register
    rasst_dp #(
        .LEAVES    (LEAVES),
        .VALUE_BITS(VALUE_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_used_length(i_cfg_used_length),
        .i_operation      (i_operation),
        .i_left           (i_left),
        .i_right          (i_right),
        .i_value          (i_value),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_range_sum      (o_range_sum),
        .o_status         (o_status)
    );

    // one request at a time: after acceptance the input side closes
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted while another is in progress");

    // a config write starts the clearing pass, which blocks requests
    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |=> !o_in_ready)
        else $error("request port open right after config write");

    // an ignored request carries a zero sum
    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status) |-> (o_range_sum == '0))
        else $error("out-of-bounds result with nonzero sum");

endmodule
